[hw/rtl/ptrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_pkg
// Shared types and constants for the proximity touch/release detector.
// ----------------------------------------------------------------------------
package ptrd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FA_W     = 17;
  localparam int unsigned DERIV_W  = 18;
  localparam int unsigned TOUCH_W  = 2;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned SENS_W   = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [SENS_W-1:0]   SENS_RESET   = 16'd50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd19661;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT      = 1'd1;

  // touch codes
  localparam logic [TOUCH_W-1:0] TOUCH_NONE    = 2'd0;
  localparam logic [TOUCH_W-1:0] TOUCH_PRESS   = 2'd1;
  localparam logic [TOUCH_W-1:0] TOUCH_RELEASE = 2'd2;

  // per-channel state
  typedef struct packed {
    logic        [SAMPLE_W-1:0] avg;
    logic signed [FA_W-1:0]     fa;
    logic signed [DERIV_W-1:0]  deriv;
    logic        [TOUCH_W-1:0]  touch;
  } chan_state_t;

endpackage

[hw/rtl/ptrd_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_update
// Next-state logic for one channel: fa, derivative, touch code and average.
// ----------------------------------------------------------------------------
module ptrd_update (
  input  ptrd_pkg::chan_state_t                   cur,
  input  logic [ptrd_pkg::SAMPLE_W-1:0]           sample,
  input  logic [ptrd_pkg::SENS_W-1:0]             sensitivity,
  input  logic [ptrd_pkg::WEIGHT_W-1:0]           smoothing_weight,
  output ptrd_pkg::chan_state_t                   upd
);

  logic signed [ptrd_pkg::FA_W-1:0]    fa;
  logic signed [ptrd_pkg::DERIV_W:0]   deriv_wide;
  logic signed [ptrd_pkg::DERIV_W:0]   sens_pos;
  logic signed [ptrd_pkg::DERIV_W:0]   sens_neg;
  logic signed [ptrd_pkg::DERIV_W:0]   deriv_old;
  logic signed [ptrd_pkg::DERIV_W:0]   fa_wide;
  logic                                crossing;
  logic [ptrd_pkg::WEIGHT_W-1:0]       w_sat;
  logic signed [ptrd_pkg::FA_W:0]      w_s;
  logic signed [ptrd_pkg::FA_W-1:0]    diff;
  logic signed [34:0]                  prod;
  logic signed [18:0]                  avg_sum;

  always_comb begin
    fa         = $signed({1'b0, cur.avg}) - $signed({1'b0, sample});
    deriv_wide = 19'(fa) - 19'(cur.fa);
    deriv_old  = 19'(cur.deriv);
    fa_wide    = 19'(fa);
    sens_pos   = $signed({3'b0, sensitivity});
    sens_neg   = -sens_pos;
    crossing   = (deriv_old < sens_neg) && (deriv_wide > sens_pos);

    upd.fa    = fa;
    upd.deriv = deriv_wide[ptrd_pkg::DERIV_W-1:0];
    upd.touch = cur.touch;
    if (crossing) begin
      if (fa_wide > sens_pos) begin
        upd.touch = ptrd_pkg::TOUCH_PRESS;
      end else if (fa_wide < sens_neg) begin
        upd.touch = ptrd_pkg::TOUCH_RELEASE;
      end else begin
        upd.touch = ptrd_pkg::TOUCH_NONE;
      end
    end

    // avg + floor(w * (sample - avg) / 2^16), same as the weighted sum
    w_sat   = (smoothing_weight > ptrd_pkg::WEIGHT_ONE) ? ptrd_pkg::WEIGHT_ONE
                                                        : smoothing_weight;
    w_s     = $signed({1'b0, w_sat});
    diff    = $signed({1'b0, sample}) - $signed({1'b0, cur.avg});
    prod    = 35'(w_s) * 35'(diff);
    avg_sum = $signed({3'b0, cur.avg}) + prod[34:16];
    upd.avg = avg_sum[ptrd_pkg::SAMPLE_W-1:0];
  end

endmodule

[hw/rtl/proximity_touch_release_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_touch_release_detector
// Per-channel fast-adapting touch/release detection on proximity samples.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  input    in   in_valid/in_stall  channel, sample
//  output   out  out_valid/out_stall out_channel, raw_value, fa_value, touch_code
//  config   in   wr_en              wr_index, wr_data
//
//  One word per cycle sustained while the output is not stalled; an accepted
//  word passes through the input register, then the result register.
//  Channel state is read and updated between the two registers and written
//  back when the word advances, so consecutive words on one channel see it.
//  Reset clears all channel state and loads the register defaults.
//  A stalled output holds its word; the input register then holds too.
// ----------------------------------------------------------------------------
module proximity_touch_release_detector #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ptrd_pkg::CHAN_W-1:0]            channel,
  input  logic [ptrd_pkg::SAMPLE_W-1:0]          sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ptrd_pkg::CHAN_W-1:0]            out_channel,
  output logic [ptrd_pkg::SAMPLE_W-1:0]          raw_value,
  output logic signed [ptrd_pkg::FA_W-1:0]       fa_value,
  output logic [ptrd_pkg::TOUCH_W-1:0]           touch_code,
  input  logic                                   wr_en,
  input  logic [ptrd_pkg::CFG_IDX_W-1:0]         wr_index,
  input  logic [ptrd_pkg::CFG_W-1:0]             wr_data
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ptrd_pkg::SENS_W-1:0]   sensitivity;
  logic [ptrd_pkg::WEIGHT_W-1:0] smoothing_weight;

  ptrd_pkg::chan_state_t state [CHANNELS];

  logic                          s1_valid;
  logic [ptrd_pkg::CHAN_W-1:0]   s1_channel;
  logic [ptrd_pkg::SAMPLE_W-1:0] s1_sample;

  logic                          advance;
  logic [4:0]                    ch_ext;
  logic                          in_range;
  logic [IDX_W-1:0]              idx;
  ptrd_pkg::chan_state_t         cur;
  ptrd_pkg::chan_state_t         upd;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  assign ch_ext   = 5'(s1_channel);
  assign in_range = ch_ext < 5'(CHANNELS);
  assign idx      = ch_ext[IDX_W-1:0];
  assign cur      = state[idx];

  ptrd_update u_update (
    .cur              (cur),
    .sample           (s1_sample),
    .sensitivity      (sensitivity),
    .smoothing_weight (smoothing_weight),
    .upd              (upd)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity      <= ptrd_pkg::SENS_RESET;
      smoothing_weight <= ptrd_pkg::WEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        ptrd_pkg::CFG_SENSITIVITY: sensitivity      <= wr_data[ptrd_pkg::SENS_W-1:0];
        ptrd_pkg::CFG_WEIGHT:      smoothing_weight <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_channel <= channel;
      s1_sample  <= sample;
    end
  end

  // channel state: write back on advance, for a channel that exists
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state[i] <= '0;
      end
    end else if (advance && in_range) begin
      state[idx] <= upd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel <= s1_channel;
      raw_value   <= s1_sample;
      // drop fa and touch for a channel that does not exist
      fa_value    <= in_range ? upd.fa : '0;
      touch_code  <= in_range ? upd.touch : ptrd_pkg::TOUCH_NONE;
    end
  end

endmodule

[tb/sv/tb_proximity_touch_release_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proximity_touch_release_detector
// Self-checking bench for the proximity touch/release detector. A queue-fed
// driver offers channel/sample words and a monitor predicts each accepted
// word's result (fast-adapting value, touch code, average update) and checks
// the result stream in order. Register settings are changed between drained
// phases. Both ends idle in random bursts, and one long output hold-off
// backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_proximity_touch_release_detector;

  localparam int CHANNELS   = 4;
  localparam int LONG_HOLD  = 120;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 4;

  typedef struct packed {
    logic [ptrd_pkg::CHAN_W-1:0]   ch;
    logic [ptrd_pkg::SAMPLE_W-1:0] smp;
  } prox_word_t;

  typedef struct packed {
    logic [ptrd_pkg::CHAN_W-1:0]      ch;
    logic [ptrd_pkg::SAMPLE_W-1:0]    raw;
    logic signed [ptrd_pkg::FA_W-1:0] fa;
    logic [ptrd_pkg::TOUCH_W-1:0]     touch;
  } prox_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [ptrd_pkg::CHAN_W-1:0]         channel = '0;
  logic [ptrd_pkg::SAMPLE_W-1:0]       sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [ptrd_pkg::CHAN_W-1:0]         out_channel;
  logic [ptrd_pkg::SAMPLE_W-1:0]       raw_value;
  logic signed [ptrd_pkg::FA_W-1:0]    fa_value;
  logic [ptrd_pkg::TOUCH_W-1:0]        touch_code;
  logic                                wr_en = 1'b0;
  logic [ptrd_pkg::CFG_IDX_W-1:0]      wr_index = '0;
  logic [ptrd_pkg::CFG_W-1:0]          wr_data = '0;

  proximity_touch_release_detector #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .channel(channel),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel(out_channel),
    .raw_value(raw_value),
    .fa_value(fa_value),
    .touch_code(touch_code),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the registers and channel state
  logic [ptrd_pkg::SENS_W-1:0]         sens_cfg;
  logic [ptrd_pkg::WEIGHT_W-1:0]       weight_cfg;
  logic [ptrd_pkg::SAMPLE_W-1:0]       avg_mem   [CHANNELS];
  logic signed [ptrd_pkg::FA_W-1:0]    fa_mem    [CHANNELS];
  logic signed [ptrd_pkg::DERIV_W-1:0] deriv_mem [CHANNELS];
  logic [ptrd_pkg::TOUCH_W-1:0]        touch_mem [CHANNELS];

  prox_word_t   sample_feed_q[$];
  prox_result_t result_due_q[$];

  bit offering;
  bit word_taken;
  bit quiet;
  bit long_hold_req;
  bit long_hold_seen;
  int send_gap;
  int stall_left;
  int hold_left;
  int idle_cycles;
  int words_in;
  int results_checked;
  int mismatches;
  int settings_used;
  int code_seen [3];
  int level [CHANNELS];

  function automatic prox_result_t predict_detector(
      input logic [ptrd_pkg::CHAN_W-1:0] ch,
      input logic [ptrd_pkg::SAMPLE_W-1:0] smp);
    prox_result_t     r;
    int               thr;
    int               fa_new;
    int               d_new;
    int               d_prev;
    longint unsigned  w;
    longint unsigned  acc;
    r.ch    = ch;
    r.raw   = smp;
    r.fa    = '0;
    r.touch = ptrd_pkg::TOUCH_NONE;
    if (ch < CHANNELS) begin
      thr    = int'(sens_cfg);
      fa_new = int'(avg_mem[ch]) - int'(smp);
      d_new  = fa_new - int'(fa_mem[ch]);
      d_prev = int'(deriv_mem[ch]);
      // reclassify only on a rising zero crossing of the derivative
      if (d_prev < -thr && d_new > thr) begin
        if (fa_new > thr)
          touch_mem[ch] = ptrd_pkg::TOUCH_PRESS;
        else if (fa_new < -thr)
          touch_mem[ch] = ptrd_pkg::TOUCH_RELEASE;
        else
          touch_mem[ch] = ptrd_pkg::TOUCH_NONE;
      end
      fa_mem[ch]    = fa_new[ptrd_pkg::FA_W-1:0];
      deriv_mem[ch] = d_new[ptrd_pkg::DERIV_W-1:0];
      w   = (weight_cfg > ptrd_pkg::WEIGHT_ONE) ? longint'(ptrd_pkg::WEIGHT_ONE)
                                                : longint'(weight_cfg);
      acc = w * longint'(smp) +
            (longint'(ptrd_pkg::WEIGHT_ONE) - w) * longint'(avg_mem[ch]);
      avg_mem[ch] = acc[31:16];
      r.fa    = fa_new[ptrd_pkg::FA_W-1:0];
      r.touch = touch_mem[ch];
    end
    return r;
  endfunction

  function automatic int clamp_sample(input int v);
    if (v < 0)
      return 0;
    if (v > 65535)
      return 65535;
    return v;
  endfunction

  // input side: drive at the falling edge, hold the word until taken
  always @(negedge clk) begin
    prox_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (word_taken) begin
        word_taken = 1'b0;
        offering   = 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0)
          send_gap = $urandom_range(1, 6);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_feed_q.size() > 0) begin
          nxt = sample_feed_q.pop_front();
          channel <= nxt.ch;
          sample  <= nxt.smp;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_seen) begin
      long_hold_seen = 1'b1;
      hold_left      = LONG_HOLD;
    end
    if (hold_left > 0)
      hold_left--;
    else if (stall_left > 0)
      stall_left--;
    else if (!quiet && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 6);
    out_stall <= (hold_left > 0) || (stall_left > 0);
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    prox_result_t due;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        result_due_q.push_back(predict_detector(channel, sample));
        word_taken = 1'b1;
        words_in++;
      end
      if (out_valid && !out_stall) begin
        if (touch_code < 3)
          code_seen[touch_code]++;
        if (result_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: ch %0d raw %0d fa %0d touch %0d",
                     out_channel, raw_value, fa_value, touch_code);
        end else begin
          due = result_due_q.pop_front();
          results_checked++;
          if (out_channel !== due.ch || raw_value !== due.raw ||
              fa_value !== due.fa || touch_code !== due.touch) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp ch %0d raw %0d fa %0d touch %0d, ",
                        "got ch %0d raw %0d fa %0d touch %0d"},
                       due.ch, due.raw, due.fa, due.touch,
                       out_channel, raw_value, fa_value, touch_code);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d words still due",
               idle_cycles, result_due_q.size());
      $display("tb_proximity_touch_release_detector: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (sample_feed_q.size() != 0 || offering || result_due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptrd_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    wait_drained();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data[ptrd_pkg::CFG_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == ptrd_pkg::CFG_SENSITIVITY)
      sens_cfg = data[ptrd_pkg::SENS_W-1:0];
    else if (idx == ptrd_pkg::CFG_WEIGHT)
      weight_cfg = data[ptrd_pkg::WEIGHT_W-1:0];
    settings_used++;
  endtask

  task automatic queue_sample(input int ch, input int smp);
    prox_word_t w;
    w.ch  = ch[ptrd_pkg::CHAN_W-1:0];
    w.smp = smp[ptrd_pkg::SAMPLE_W-1:0];
    sample_feed_q.push_back(w);
  endtask

  // mostly slow drift and press/return pulses per channel, some raw noise
  task automatic queue_random(input int count);
    int ch;
    int big;
    for (int n = 0; n < count; n++) begin
      ch = int'($urandom_range(0, CHANNELS - 1));
      case ($urandom_range(0, 9))
        0, 1, 2: queue_sample(ch, int'($urandom_range(0, 65535)));
        3, 4, 5, 6: begin
          level[ch] = clamp_sample(level[ch] + int'($urandom_range(0, 64)) - 32);
          queue_sample(ch, clamp_sample(level[ch] + int'($urandom_range(0, 400)) - 200));
        end
        7, 8: begin
          big = int'($urandom_range(500, 20000));
          if ($urandom_range(0, 1) == 1)
            big = -big;
          queue_sample(ch, clamp_sample(level[ch] + big));
          queue_sample(ch, level[ch]);
        end
        default: queue_sample(ch, ($urandom_range(0, 1) == 1) ? 65535 : 0);
      endcase
    end
  endtask

  initial begin
    sens_cfg   = ptrd_pkg::SENS_RESET;
    weight_cfg = ptrd_pkg::WEIGHT_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      avg_mem[i]   = '0;
      fa_mem[i]    = '0;
      deriv_mem[i] = '0;
      touch_mem[i] = ptrd_pkg::TOUCH_NONE;
      level[i]     = int'($urandom_range(0, 65535));
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: full-scale swings give a press, a rise then partial fall a release
    queue_sample(0, 65535);
    queue_sample(0, 0);
    queue_sample(0, 65535);
    queue_sample(0, 0);
    queue_sample(1, 60000);
    queue_sample(1, 19000);

    // unit weight: the average tracks the last sample, so fa is a plain difference
    write_reg(ptrd_pkg::CFG_WEIGHT, int'(ptrd_pkg::WEIGHT_ONE));
    queue_sample(2, 1000);
    queue_sample(2, 0);
    queue_sample(2, 2000);
    queue_sample(2, 2010);
    queue_sample(2, 5000);
    queue_sample(2, 4000);

    // top bit of the write is dropped for the 16-bit threshold
    write_reg(ptrd_pkg::CFG_SENSITIVITY, 131071);
    queue_sample(3, 65535);
    queue_sample(3, 0);
    queue_sample(3, 65535);
    queue_sample(3, 0);

    // zero weight freezes the average; zero threshold
    write_reg(ptrd_pkg::CFG_SENSITIVITY, 0);
    write_reg(ptrd_pkg::CFG_WEIGHT, 0);
    queue_sample(0, 1);
    queue_sample(0, 65535);
    queue_sample(0, 0);

    // weight above one saturates
    write_reg(ptrd_pkg::CFG_WEIGHT, 131071);
    queue_sample(1, 43690);
    queue_sample(1, 21845);

    write_reg(ptrd_pkg::CFG_SENSITIVITY, int'(ptrd_pkg::SENS_RESET));
    write_reg(ptrd_pkg::CFG_WEIGHT, int'(ptrd_pkg::WEIGHT_RESET));
    queue_random(400);

    write_reg(ptrd_pkg::CFG_SENSITIVITY, 0);
    write_reg(ptrd_pkg::CFG_WEIGHT, int'(ptrd_pkg::WEIGHT_ONE));
    queue_random(200);

    write_reg(ptrd_pkg::CFG_SENSITIVITY, 65535);
    write_reg(ptrd_pkg::CFG_WEIGHT, 0);
    queue_random(150);

    write_reg(ptrd_pkg::CFG_SENSITIVITY, 300);
    write_reg(ptrd_pkg::CFG_WEIGHT, 131071);
    queue_random(200);

    // fill the feed, then hold the output off so the block backs up
    write_reg(ptrd_pkg::CFG_SENSITIVITY, $urandom_range(0, 1000));
    write_reg(ptrd_pkg::CFG_WEIGHT, $urandom_range(0, 131071));
    queue_random(300);
    long_hold_req = 1'b1;

    write_reg(ptrd_pkg::CFG_SENSITIVITY, $urandom_range(0, 65535));
    write_reg(ptrd_pkg::CFG_WEIGHT, $urandom_range(0, 131071));
    queue_random(250);

    // closing stretch at full rate on both sides
    write_reg(ptrd_pkg::CFG_SENSITIVITY, int'(ptrd_pkg::SENS_RESET));
    write_reg(ptrd_pkg::CFG_WEIGHT, int'(ptrd_pkg::WEIGHT_ONE) + 1);
    quiet = 1'b1;
    queue_random(400);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("%0d samples over %0d register writes, %0d results checked, %0d mismatches",
             words_in, settings_used, results_checked, mismatches);
    $display("touch codes seen: none %0d, press %0d, release %0d; long output hold %0s",
             code_seen[0], code_seen[1], code_seen[2], long_hold_seen ? "done" : "missed");
    if (mismatches == 0 && result_due_q.size() == 0)
      $display("tb_proximity_touch_release_detector: PASS");
    else
      $display("tb_proximity_touch_release_detector: FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ptrd_pkg.sv
hw/rtl/ptrd_update.sv
hw/rtl/proximity_touch_release_detector.sv
tb/sv/tb_proximity_touch_release_detector.sv
